// ===== hdl/rrr_pkg.sv =====
// ----------------------------------------------------------------------------
// rrr_pkg: shared types, constants and helpers of the ray bounce core
// Holds the fixed field widths, the opcode codes, the item word that travels
// down the pipeline and the output saturation helpers.
// ----------------------------------------------------------------------------
package rrr_pkg;

  localparam int IN_W    = 19;   // input vector component width
  localparam int OUT_W   = 21;   // output vector component width
  localparam int DOT_W   = 40;   // exact dot product width
  localparam int SPLIT_W = 20;   // low half of the dot product for the reflect multiply

  localparam logic OP_REFLECT = 1'b0;
  localparam logic OP_REFRACT = 1'b1;

  // Largest positive value of a signed output component.
  localparam logic signed [63:0] OUT_MAXV = 64'sd1048575;

  typedef struct packed {
    logic                   opcode;
    logic [2:0][IN_W-1:0]   v;
    logic [2:0][IN_W-1:0]   n;
    logic [IN_W-1:0]        eta;
  } item_t;

  // Output saturation limit: 8.0, or the largest output code if 8.0 does not fit.
  function automatic logic signed [63:0] out_lim(input int frac);
    logic signed [63:0] eight;
    eight = 64'sd8 <<< frac;
    return (eight > OUT_MAXV) ? OUT_MAXV : eight;
  endfunction

  // Clamp a value to plus or minus lim and cut it to the output width.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] x,
                                                      input logic signed [63:0] lim);
    logic signed [63:0] r;
    r = x;
    if (x > lim) begin
      r = lim;
    end else if (x < -lim) begin
      r = -lim;
    end
    return r[OUT_W-1:0];
  endfunction

endpackage

// ===== hdl/rrr_dot.sv =====
// ----------------------------------------------------------------------------
// rrr_dot: dot product front end
// Two stages: the three component products, then their exact sum.
// ----------------------------------------------------------------------------
module rrr_dot import rrr_pkg::*; (
  input  logic                     clk_i,
  input  logic [1:0]               adv_i,
  input  item_t                    item_i,
  output item_t                    item_o,
  output logic signed [DOT_W-1:0]  dot_o
);

  logic signed [2*IN_W-1:0] prod_d [3];
  logic signed [2*IN_W-1:0] prod_q [3];
  logic signed [DOT_W-1:0]  dot_d;
  logic signed [DOT_W-1:0]  dot_q;
  item_t                    itm_q [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = $signed(item_i.v[i]) * $signed(item_i.n[i]);
    end
    dot_d = DOT_W'(prod_q[0]) + DOT_W'(prod_q[1]) + DOT_W'(prod_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      prod_q   <= prod_d;
      itm_q[0] <= item_i;
    end
    if (adv_i[1]) begin
      dot_q    <= dot_d;
      itm_q[1] <= itm_q[0];
    end
  end

  assign item_o = itm_q[1];
  assign dot_o  = dot_q;

endmodule

// ===== hdl/rrr_perp.sv =====
// ----------------------------------------------------------------------------
// rrr_perp: reflect result and refraction perpendicular part
// Nine stages. The reflect result is finished and saturated in the first
// four; the refract side forms the clamped cosine, the perpendicular vector
// p and the distance |1 - p.p| that feeds the square root.
// ----------------------------------------------------------------------------
module rrr_perp import rrr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic [8:0]                    adv_i,
  input  item_t                         item_i,
  input  logic signed [DOT_W-1:0]       dot_i,
  output item_t                         item_o,
  output logic signed [FRAC_BITS+8:0]   p_o [3],
  output logic signed [OUT_W-1:0]       refl_o [3],
  output logic [2*FRAC_BITS+15:0]       s_o
);

  localparam int F    = FRAC_BITS;
  localparam int C2W  = (DOT_W + 1 > 2*F + 2) ? DOT_W + 1 : 2*F + 2;
  localparam int CW   = C2W + 1 - F;
  localparam int CNW  = CW + IN_W;
  localparam int TSW  = ((IN_W + F > CNW) ? IN_W + F : CNW) + 1;
  localparam int TW   = TSW + 1 - F;
  localparam int TEW  = TW + IN_W + 1;
  localparam int PRW  = TEW + 1 - F;
  localparam int PW   = F + 9;
  localparam int PXW  = ((PRW > PW) ? PRW : PW) + 1;
  localparam int PMW  = F + 8;
  localparam int SQW  = 2*F + 16;
  localparam int HIW  = DOT_W - SPLIT_W + IN_W;
  localparam int LOW  = SPLIT_W + 1 + IN_W;
  localparam int RPW  = DOT_W + IN_W;
  localparam int RRW  = RPW + 2 - 2*F;
  localparam int RVW  = ((IN_W > RRW) ? IN_W : RRW) + 1;

  localparam logic signed [C2W-1:0] ONE2     = C2W'(1) << (2*F);
  localparam logic [C2W:0]          CF_HALF  = (C2W+1)'(1) << (F-1);
  localparam logic [TSW:0]          T_HALF   = (TSW+1)'(1) << (F-1);
  localparam logic [TEW:0]          TE_HALF  = (TEW+1)'(1) << (F-1);
  localparam logic [RPW:0]          RR_HALF  = (RPW+1)'(1) << (2*F-2);
  localparam logic signed [PXW-1:0] PLIM     = PXW'(128) << F;
  localparam logic [SQW-1:0]        ONE2U    = SQW'(1) << (2*F);
  localparam logic signed [63:0]    LIM      = out_lim(F);

  item_t                     itm_q [9];
  // refract path
  logic signed [C2W-1:0]     neg_c, c2_d, c2_q;
  logic [C2W:0]              cfs_c;
  logic signed [CW-1:0]      cf_q;
  logic signed [CNW-1:0]     cn_q  [3];
  logic [TSW:0]              ts_c  [3];
  logic signed [TW-1:0]      t_q   [3];
  logic signed [TEW-1:0]     te_q  [3];
  logic [TEW:0]              tr_c  [3];
  logic signed [PXW-1:0]     px_c  [3];
  logic signed [PW-1:0]      p_d   [3];
  logic signed [PW-1:0]      p_q   [4][3];
  logic [PMW-1:0]            pm_c  [3];
  logic [SQW-1:0]            sq_q  [3];
  logic [SQW-1:0]            len_q;
  logic [SQW-1:0]            s_d, s_q;
  // reflect path
  logic signed [HIW-1:0]     hi_q  [3];
  logic signed [LOW-1:0]     lo_q  [3];
  logic signed [RPW-1:0]     rsum_q [3];
  logic [RPW:0]              rr_c  [3];
  logic signed [RRW-1:0]     rr_q  [3];
  logic signed [RVW-1:0]     rv_c  [3];
  logic signed [OUT_W-1:0]   refl_d [3];
  logic signed [OUT_W-1:0]   refl_q [6][3];

  always_comb begin
    // Cosine term: -(v.n) limited to 1.0, then rounded to F fraction bits.
    neg_c = -(C2W'(dot_i));
    c2_d  = (neg_c > ONE2) ? ONE2 : neg_c;
    cfs_c = (C2W+1)'(c2_q) + CF_HALF;
    for (int i = 0; i < 3; i++) begin
      ts_c[i]   = ((TSW+1)'($signed(itm_q[2].v[i])) <<< F) + (TSW+1)'(cn_q[i]) + T_HALF;
      tr_c[i]   = (TEW+1)'(te_q[i]) + TE_HALF;
      px_c[i]   = PXW'($signed(tr_c[i][TEW:F]));
      if (px_c[i] > PLIM) begin
        p_d[i] = PW'(PLIM);
      end else if (px_c[i] < -PLIM) begin
        p_d[i] = PW'(-PLIM);
      end else begin
        p_d[i] = px_c[i][PW-1:0];
      end
      pm_c[i]   = p_q[0][i][PW-1] ? PMW'(-p_q[0][i]) : PMW'(p_q[0][i]);
      rr_c[i]   = (RPW+1)'(rsum_q[i]) + RR_HALF;
      rv_c[i]   = RVW'($signed(itm_q[2].v[i])) - RVW'(rr_q[i]);
      refl_d[i] = sat_out(64'(rv_c[i]), LIM);
    end
    s_d = (len_q >= ONE2U) ? (len_q - ONE2U) : (ONE2U - len_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      itm_q[0] <= item_i;
      c2_q     <= c2_d;
      for (int i = 0; i < 3; i++) begin
        hi_q[i] <= $signed(dot_i[DOT_W-1:SPLIT_W]) * $signed(item_i.n[i]);
        lo_q[i] <= $signed({1'b0, dot_i[SPLIT_W-1:0]}) * $signed(item_i.n[i]);
      end
    end
    if (adv_i[1]) begin
      itm_q[1] <= itm_q[0];
      cf_q     <= cfs_c[C2W:F];
      for (int i = 0; i < 3; i++) begin
        rsum_q[i] <= (RPW'(hi_q[i]) <<< SPLIT_W) + RPW'(lo_q[i]);
      end
    end
    if (adv_i[2]) begin
      itm_q[2] <= itm_q[1];
      for (int i = 0; i < 3; i++) begin
        cn_q[i] <= cf_q * $signed(itm_q[1].n[i]);
        rr_q[i] <= rr_c[i][RPW:2*F-1];
      end
    end
    if (adv_i[3]) begin
      itm_q[3]  <= itm_q[2];
      refl_q[0] <= refl_d;
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= ts_c[i][TSW:F];
      end
    end
    if (adv_i[4]) begin
      itm_q[4]  <= itm_q[3];
      refl_q[1] <= refl_q[0];
      for (int i = 0; i < 3; i++) begin
        te_q[i] <= t_q[i] * $signed({1'b0, itm_q[3].eta});
      end
    end
    if (adv_i[5]) begin
      itm_q[5]  <= itm_q[4];
      refl_q[2] <= refl_q[1];
      p_q[0]    <= p_d;
    end
    if (adv_i[6]) begin
      itm_q[6]  <= itm_q[5];
      refl_q[3] <= refl_q[2];
      p_q[1]    <= p_q[0];
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQW'(pm_c[i]) * SQW'(pm_c[i]);
      end
    end
    if (adv_i[7]) begin
      itm_q[7]  <= itm_q[6];
      refl_q[4] <= refl_q[3];
      p_q[2]    <= p_q[1];
      len_q     <= sq_q[0] + sq_q[1] + sq_q[2];
    end
    if (adv_i[8]) begin
      itm_q[8]  <= itm_q[7];
      refl_q[5] <= refl_q[4];
      p_q[3]    <= p_q[2];
      s_q       <= s_d;
    end
  end

  assign item_o = itm_q[8];
  assign p_o    = p_q[3];
  assign refl_o = refl_q[5];
  assign s_o    = s_q;

endmodule

// ===== hdl/rrr_sqrt.sv =====
// ----------------------------------------------------------------------------
// rrr_sqrt: pipelined integer square root, rounded to nearest
// One root bit per stage by restoring digit recurrence, then one stage that
// rounds up when the remainder exceeds the root. A side word rides along.
// ----------------------------------------------------------------------------
module rrr_sqrt import rrr_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 8
) (
  input  logic                          clk_i,
  input  logic [FRAC_BITS+8:0]          adv_i,
  input  logic [2*FRAC_BITS+15:0]       s_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic [FRAC_BITS+8:0]          root_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int RB = FRAC_BITS + 8;
  localparam int SW = 2 * RB;

  logic [RB+1:0]     rem_q  [RB];
  logic [RB-1:0]     root_q [RB];
  logic [SW-1:0]     sv_q   [RB];
  logic [SIDE_W-1:0] side_q [RB+1];
  logic [RB:0]       rnd_q;

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam int J = RB - 1 - k;
    logic [RB+1:0]     rem_in;
    logic [RB-1:0]     root_in;
    logic [SW-1:0]     s_in;
    logic [SIDE_W-1:0] side_in;
    logic [RB+1:0]     rem_sh, trial, rem_d;
    logic [RB-1:0]     root_d;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = s_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = sv_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[RB-1:0], s_in[2*J+1:2*J]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[RB-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[RB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[k]) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        sv_q[k]   <= s_in;
        side_q[k] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[RB]) begin
      rnd_q      <= {1'b0, root_q[RB-1]} +
                    (RB+1)'(rem_q[RB-1] > (RB+2)'(root_q[RB-1]));
      side_q[RB] <= side_q[RB-1];
    end
  end

  assign root_o = rnd_q;
  assign side_o = side_q[RB];

endmodule

// ===== hdl/rrr_tail.sv =====
// ----------------------------------------------------------------------------
// rrr_tail: refraction back end and output register
// Multiplies the root by the normal, subtracts it from p with rounding, then
// saturates and selects between the reflect and refract results.
// ----------------------------------------------------------------------------
module rrr_tail import rrr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic [2:0]                    adv_i,
  input  item_t                         item_i,
  input  logic [FRAC_BITS+8:0]          root_i,
  input  logic signed [FRAC_BITS+8:0]   p_i [3],
  input  logic signed [OUT_W-1:0]       refl_i [3],
  output logic signed [OUT_W-1:0]       out_o [3]
);

  localparam int F   = FRAC_BITS;
  localparam int RB  = F + 8;
  localparam int PW  = F + 9;
  localparam int RNW = RB + 2 + IN_W;
  localparam int DFW = ((PW + F > RNW) ? PW + F : RNW) + 2;
  localparam logic [DFW-1:0]       HALF = DFW'(1) << (F-1);
  localparam logic signed [63:0]   LIM  = out_lim(F);

  logic signed [RNW-1:0]     rn_q   [3];
  logic signed [PW-1:0]      p_q    [3];
  logic signed [OUT_W-1:0]   refl_q [2][3];
  logic                      op_q   [2];
  logic [DFW-1:0]            df_c   [3];
  logic signed [DFW-F-1:0]   res_q  [3];
  logic signed [OUT_W-1:0]   out_d  [3];
  logic signed [OUT_W-1:0]   out_q  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df_c[i]  = (DFW'(p_q[i]) <<< F) - DFW'(rn_q[i]) + HALF;
      out_d[i] = (op_q[1] == OP_REFRACT) ? sat_out(64'(res_q[i]), LIM) : refl_q[1][i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      op_q[0]   <= item_i.opcode;
      p_q       <= p_i;
      refl_q[0] <= refl_i;
      for (int i = 0; i < 3; i++) begin
        rn_q[i] <= $signed({1'b0, root_i}) * $signed(item_i.n[i]);
      end
    end
    if (adv_i[1]) begin
      op_q[1]   <= op_q[0];
      refl_q[1] <= refl_q[0];
      for (int i = 0; i < 3; i++) begin
        res_q[i] <= df_c[i][DFW-1:F];
      end
    end
    if (adv_i[2]) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== hdl/ray_reflect_refract_core.sv =====
// ----------------------------------------------------------------------------
// ray_reflect_refract_core: reflection and refraction of a ray direction
// Takes one word per cycle while in_ready_o is high: an opcode, an incident
// vector, a surface normal and an index ratio, and returns the reflected or refracted direction.
//
// Input channel (in_valid_i / in_ready_o) carries the opcode, the incident
// vector in_*, the normal norm_* and eta_ratio_i, all fixed point with
// FRAC_BITS fraction bits. Output channel (out_valid_o / out_ready_i)
// carries the result vector out_*, saturated at plus or minus 8.0 (or the largest output code).
// The pipeline has two stages for the dot product, nine for the reflect
// result and the refraction vector, one per root bit plus one rounding stage
// in the square root unit, and three for the back end and the output register.
// Throughput is one word per cycle while out_ready_i stays high; the square
// root is fully pipelined, so reflect and refract words may be mixed freely.
// Reset clears every stage valid bit; no word is in flight afterwards.
// When the receiver stalls, the last stage holds its word and the stages
// behind it keep moving until they fill, so bubbles are squeezed out and
// in_ready_o falls only once every stage holds a word.
// ----------------------------------------------------------------------------
module ray_reflect_refract_core import rrr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     opcode_i,
  input  logic signed [IN_W-1:0]   in_x_i,
  input  logic signed [IN_W-1:0]   in_y_i,
  input  logic signed [IN_W-1:0]   in_z_i,
  input  logic signed [IN_W-1:0]   norm_x_i,
  input  logic signed [IN_W-1:0]   norm_y_i,
  input  logic signed [IN_W-1:0]   norm_z_i,
  input  logic [IN_W-1:0]          eta_ratio_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [OUT_W-1:0]  out_x_o,
  output logic signed [OUT_W-1:0]  out_y_o,
  output logic signed [OUT_W-1:0]  out_z_o
);

  localparam int RB     = FRAC_BITS + 8;     // root bits
  localparam int PW     = FRAC_BITS + 9;     // perpendicular component width
  localparam int SW     = 2 * RB;            // square root argument width
  localparam int SIDE_W = $bits(item_t) + 3*PW + 3*OUT_W;
  // Stage map: dot 0..1, perp 2..10, sqrt 11..RB+11, tail RB+12..RB+14.
  localparam int NST    = RB + 15;
  localparam int P0     = 2;
  localparam int Q0     = 11;
  localparam int T0     = RB + 12;
  localparam logic signed [OUT_W-1:0] LIM_O = OUT_W'(out_lim(FRAC_BITS));

  // Per-stage valid bits and the ready chain. A stage loads whenever it is
  // empty or the stage after it is loading, so a stall only stops the
  // stages that are full all the way back from the output.
  logic [NST-1:0] vld_q, vld_d;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d = {vld_q[NST-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NST-1];

  // Input word.
  item_t in_item;
  always_comb begin
    in_item.opcode = opcode_i;
    in_item.v[0]   = in_x_i;
    in_item.v[1]   = in_y_i;
    in_item.v[2]   = in_z_i;
    in_item.n[0]   = norm_x_i;
    in_item.n[1]   = norm_y_i;
    in_item.n[2]   = norm_z_i;
    in_item.eta    = eta_ratio_i;
  end

  item_t                     dot_item;
  logic signed [DOT_W-1:0]   dot;

  rrr_dot u_dot (
    .clk_i  (clk_i),
    .adv_i  (rdy[1:0]),
    .item_i (in_item),
    .item_o (dot_item),
    .dot_o  (dot)
  );

  item_t                     perp_item;
  logic signed [PW-1:0]      perp_p    [3];
  logic signed [OUT_W-1:0]   perp_refl [3];
  logic [SW-1:0]             perp_s;

  rrr_perp #(.FRAC_BITS(FRAC_BITS)) u_perp (
    .clk_i  (clk_i),
    .adv_i  (rdy[Q0-1:P0]),
    .item_i (dot_item),
    .dot_i  (dot),
    .item_o (perp_item),
    .p_o    (perp_p),
    .refl_o (perp_refl),
    .s_o    (perp_s)
  );

  // Everything the back end needs rides through the square root unit.
  logic [SIDE_W-1:0]         side_in, side_out;
  logic [RB:0]               root;
  item_t                     sq_item;
  logic signed [PW-1:0]      sq_p    [3];
  logic signed [OUT_W-1:0]   sq_refl [3];

  assign side_in = {perp_item, perp_p[2], perp_p[1], perp_p[0],
                    perp_refl[2], perp_refl[1], perp_refl[0]};

  rrr_sqrt #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_sqrt (
    .clk_i  (clk_i),
    .adv_i  (rdy[T0-1:Q0]),
    .s_i    (perp_s),
    .side_i (side_in),
    .root_o (root),
    .side_o (side_out)
  );

  assign {sq_item, sq_p[2], sq_p[1], sq_p[0], sq_refl[2], sq_refl[1], sq_refl[0]} = side_out;

  logic signed [OUT_W-1:0]   res [3];

  rrr_tail #(.FRAC_BITS(FRAC_BITS)) u_tail (
    .clk_i  (clk_i),
    .adv_i  (rdy[NST-1:T0]),
    .item_i (sq_item),
    .root_i (root),
    .p_i    (sq_p),
    .refl_i (sq_refl),
    .out_o  (res)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];

  // The input side can only be blocked by a word waiting at the output.
  a_block_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input blocked without an output stall");

  // Every delivered component lies within the saturation limit.
  a_out_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_x_o <= LIM_O && out_x_o >= -LIM_O))
    else $error("out_x beyond saturation limit");

  a_out_yz_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_y_o <= LIM_O && out_y_o >= -LIM_O &&
                     out_z_o <= LIM_O && out_z_o >= -LIM_O))
    else $error("out_y or out_z beyond saturation limit");

endmodule
